// ----- rtl/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg: shared definitions for the cartridge bank mapper
// Request kinds, mapping target codes and the widths and constants that the
// mapper and its port checker both use.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // request kinds on s_tuser
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // mapping targets on m_tuser
  localparam logic [2:0] TGT_NONE     = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM  = 3'd1;
  localparam logic [2:0] TGT_CHR_ROM  = 3'd2;
  localparam logic [2:0] TGT_CHR_RAM  = 3'd3;
  localparam logic [2:0] TGT_NT_RAM   = 3'd4;

  // configuration register indexes
  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  localparam int PRG_COUNT_W = 7;
  localparam int CHR_COUNT_W = 9;
  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 7'd64;
  localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 9'd256;

  localparam int PATTERN_SLOTS = 8;
  localparam int NT_SLOTS      = 4;
  localparam int RAM_PAGES     = 32;

  localparam logic [14:0] CNT_MAX  = 15'h7FFF;
  localparam logic [7:0]  RAM_BASE = 8'hE0;

  // remainder unit: 8-bit dividend, two quotient bits per cycle
  localparam int DIV_NUM_W      = 8;
  localparam int DIV_DEN_W      = 9;
  localparam int DIV_BITS_CYCLE = 2;
  localparam int DIV_CYCLES     = DIV_NUM_W / DIV_BITS_CYCLE;

endpackage

// ----- rtl/cartridge_bank_mapper_with_irq.sv -----
// Sequence: an accepted request goes straight to the done state unless a page wraps;
//   a wrapping page first passes through the shared 2-bit-per-cycle remainder unit.
// Only one request is in flight at a time: s_tready is low while it is. The output
//   register lets the next request in while a result waits.
// Reset (rst, synchronous): state and bank registers clear, page counts go to 64 and 256.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq: banked cartridge mapper with tick-counter IRQ
// CPU register writes/reads, PPU pattern/nametable lookups and a 15-bit
// up-counter that raises an IRQ at its top. Page wrap is a restoring remainder.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] data
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] read_data, [8] irq_line, [16:9] map_page, rest 0
  output logic [2:0]  m_tuser,   // [2:0] map_target
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // CPU register selectors, address[15:11]
  localparam logic [4:0] RS_CNT_LO   = 5'h0A;  // 0x5000
  localparam logic [4:0] RS_CNT_HI   = 5'h0B;  // 0x5800
  localparam logic [4:0] RS_PAT_LO   = 5'h10;  // 0x8000
  localparam logic [4:0] RS_PAT_HI   = 5'h17;  // 0xB800
  localparam logic [4:0] RS_NT_LO    = 5'h18;  // 0xC000
  localparam logic [4:0] RS_NT_HI    = 5'h1B;  // 0xD800
  localparam logic [4:0] RS_PRG_LO   = 5'h1C;  // 0xE000
  localparam logic [4:0] RS_CTRL     = 5'h1D;  // 0xE800
  localparam logic [4:0] RS_PRG_HI   = 5'h1E;  // 0xF000

  localparam int SLOT_W = $clog2(cbm_pkg::PATTERN_SLOTS);
  localparam int NT_W   = $clog2(cbm_pkg::NT_SLOTS);
  localparam int STEP_W = $clog2(cbm_pkg::DIV_CYCLES);
  localparam int PRG_COUNT_W_L = cbm_pkg::PRG_COUNT_W;

  // configuration
  logic [cbm_pkg::PRG_COUNT_W-1:0] prg_page_count;
  logic [cbm_pkg::CHR_COUNT_W-1:0] chr_page_count;

  // mapper state
  logic [14:0] irq_count;
  logic        irq_enable;
  logic        irq_pending;
  logic [1:0]  tick_prescale;
  logic [7:0]  pattern_bank [cbm_pkg::PATTERN_SLOTS];
  logic [7:0]  nametable_sel [cbm_pkg::NT_SLOTS];
  logic [5:0]  prg_bank_low;
  logic [7:0]  ctrl_e800;
  logic [5:0]  prg_bank_high;

  // sequencer and divide unit
  logic [1:0]  state;
  logic [STEP_W-1:0] step;
  logic [cbm_pkg::DIV_NUM_W-1:0] div_num;
  logic [cbm_pkg::DIV_DEN_W-1:0] div_den;
  logic [cbm_pkg::DIV_DEN_W-1:0] div_rem;

  // result being built
  logic [7:0]  res_rd;
  logic        res_irq;
  logic [2:0]  res_tgt;
  logic [7:0]  res_page;

  // output register
  logic [7:0]  out_rd;
  logic        out_irq;
  logic [2:0]  out_tgt;
  logic [7:0]  out_page;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // request fields
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  wdat;
  logic [4:0]  rsel;
  assign cmd  = s_tuser;
  assign addr = s_tdata[15:0];
  assign wdat = s_tdata[23:16];
  assign rsel = addr[15:11];

  // ---------------------------------------------------------------------------
  // Decode at accept: state updates plus the result, or the operands for the
  // remainder unit when a page must wrap.
  // ---------------------------------------------------------------------------
  logic [14:0] count_next;
  logic        enable_next;
  logic        pending_next;
  logic [1:0]  prescale_next;
  logic        pat_we, nt_we, prg_lo_we, ctrl_we, prg_hi_we;
  logic [SLOT_W-1:0] pat_idx;
  logic [NT_W-1:0]   nt_idx;
  logic [7:0]  acc_rd;
  logic [2:0]  acc_tgt;
  logic [7:0]  acc_page;
  logic        acc_mod;
  logic [cbm_pkg::DIV_NUM_W-1:0] acc_num;
  logic [cbm_pkg::DIV_DEN_W-1:0] acc_den;
  logic        in_reg_win;
  logic        in_io_win;
  logic [PRG_COUNT_W_L-1:0] prg_bank;
  logic [7:0]  chr_bank;
  logic        rom_only;

  always_comb begin
    count_next    = irq_count;
    enable_next   = irq_enable;
    pending_next  = irq_pending;
    prescale_next = tick_prescale;
    pat_we        = 1'b0;
    nt_we         = 1'b0;
    prg_lo_we     = 1'b0;
    ctrl_we       = 1'b0;
    prg_hi_we     = 1'b0;
    pat_idx       = rsel[SLOT_W-1:0];
    nt_idx        = rsel[NT_W-1:0];
    acc_rd        = 8'd0;
    acc_tgt       = cbm_pkg::TGT_NONE;
    acc_page      = 8'd0;
    acc_mod       = 1'b0;
    acc_num       = '0;
    acc_den       = '0;
    prg_bank      = '0;
    chr_bank      = 8'd0;
    rom_only      = 1'b0;
    in_io_win     = (addr >= 16'h4800) && (addr < 16'h6000);
    in_reg_win    = in_io_win || addr[15];

    case (cmd)
      cbm_pkg::CMD_WRITE: begin
        if (in_reg_win) begin
          if (rsel == RS_CNT_LO) begin
            count_next   = {irq_count[14:8], wdat};
            pending_next = 1'b0;
          end else if (rsel == RS_CNT_HI) begin
            count_next   = {wdat[6:0], irq_count[7:0]};
            enable_next  = wdat[7];
            pending_next = 1'b0;
          end else if (rsel inside {[RS_PAT_LO:RS_PAT_HI]}) begin
            pat_we = 1'b1;
          end else if (rsel inside {[RS_NT_LO:RS_NT_HI]}) begin
            nt_we = 1'b1;
          end else if (rsel == RS_PRG_LO) begin
            prg_lo_we = 1'b1;
          end else if (rsel == RS_CTRL) begin
            ctrl_we = 1'b1;
          end else if (rsel == RS_PRG_HI) begin
            prg_hi_we = 1'b1;
          end
        end
      end
      cbm_pkg::CMD_READ: begin
        if (in_io_win) begin
          if (rsel == RS_CNT_LO) begin
            acc_rd       = irq_count[7:0];
            pending_next = 1'b0;
          end else if (rsel == RS_CNT_HI) begin
            acc_rd       = {1'b0, irq_count[14:8]};
            pending_next = 1'b0;
          end
        end else if (addr[15]) begin
          case (addr[14:13])
            2'd0:    prg_bank = {1'b0, prg_bank_low};
            2'd1:    prg_bank = {1'b0, ctrl_e800[5:0]};
            2'd2:    prg_bank = {1'b0, prg_bank_high};
            default: prg_bank = prg_page_count - 1'b1;
          endcase
          acc_tgt = cbm_pkg::TGT_PRG_ROM;
          // zero page count acts as one page: everything maps to page 0
          if (prg_page_count != '0) begin
            acc_mod = 1'b1;
            acc_num = cbm_pkg::DIV_NUM_W'(prg_bank);
            acc_den = cbm_pkg::DIV_DEN_W'(prg_page_count);
          end
        end
      end
      cbm_pkg::CMD_LOOKUP: begin
        if (addr[15:13] == 3'd0) begin
          chr_bank = pattern_bank[addr[10 +: SLOT_W]];
          rom_only = addr[12] ? ctrl_e800[7] : ctrl_e800[6];
          if (chr_bank < cbm_pkg::RAM_BASE || rom_only) begin
            acc_tgt = cbm_pkg::TGT_CHR_ROM;
            if (chr_page_count != '0) begin
              acc_mod = 1'b1;
              acc_num = chr_bank;
              acc_den = chr_page_count;
            end
          end else begin
            acc_tgt  = cbm_pkg::TGT_CHR_RAM;
            acc_page = (chr_bank - cbm_pkg::RAM_BASE) & 8'(cbm_pkg::RAM_PAGES - 1);
          end
        end else if (addr < 16'h3000) begin
          chr_bank = nametable_sel[addr[10 +: NT_W]];
          if (chr_bank >= cbm_pkg::RAM_BASE) begin
            acc_tgt  = cbm_pkg::TGT_NT_RAM;
            acc_page = {7'd0, chr_bank[0]};
          end else begin
            acc_tgt = cbm_pkg::TGT_CHR_ROM;
            if (chr_page_count != '0) begin
              acc_mod = 1'b1;
              acc_num = chr_bank;
              acc_den = chr_page_count;
            end
          end
        end
      end
      default: begin
        // tick: on every third one an enabled counter advances, or raises the IRQ at its top
        if (tick_prescale == 2'd2) begin
          prescale_next = 2'd0;
          if (irq_enable) begin
            if (irq_count >= cbm_pkg::CNT_MAX) begin
              pending_next = 1'b1;
            end else begin
              count_next = irq_count + 15'd1;
            end
          end
        end else begin
          prescale_next = tick_prescale + 2'd1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared remainder unit: restoring division, two dividend bits per cycle.
  // ---------------------------------------------------------------------------
  logic [cbm_pkg::DIV_DEN_W:0]   div_try;
  logic [cbm_pkg::DIV_DEN_W-1:0] rem_w;
  logic [cbm_pkg::DIV_NUM_W-1:0] num_w;

  always_comb begin
    rem_w   = div_rem;
    num_w   = div_num;
    div_try = '0;
    for (int i = 0; i < cbm_pkg::DIV_BITS_CYCLE; i++) begin
      div_try = {rem_w, num_w[cbm_pkg::DIV_NUM_W-1]};
      num_w   = {num_w[cbm_pkg::DIV_NUM_W-2:0], 1'b0};
      if (div_try >= {1'b0, div_den}) begin
        div_try = div_try - {1'b0, div_den};
      end
      rem_w = div_try[cbm_pkg::DIV_DEN_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_page_count <= cbm_pkg::PRG_COUNT_RESET;
      chr_page_count <= cbm_pkg::CHR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cbm_pkg::CFG_PRG_COUNT: prg_page_count <= cfg_data[cbm_pkg::PRG_COUNT_W-1:0];
        default:                chr_page_count <= cfg_data;
      endcase
    end
  end

  // mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_count     <= '0;
      irq_enable    <= 1'b0;
      irq_pending   <= 1'b0;
      tick_prescale <= '0;
      prg_bank_low  <= '0;
      ctrl_e800     <= '0;
      prg_bank_high <= '0;
      for (int i = 0; i < cbm_pkg::PATTERN_SLOTS; i++) pattern_bank[i] <= '0;
      for (int i = 0; i < cbm_pkg::NT_SLOTS; i++) nametable_sel[i] <= '0;
    end else if (accept) begin
      irq_count     <= count_next;
      irq_enable    <= enable_next;
      irq_pending   <= pending_next;
      tick_prescale <= prescale_next;
      if (pat_we)    pattern_bank[pat_idx] <= wdat;
      if (nt_we)     nametable_sel[nt_idx] <= wdat;
      if (prg_lo_we) prg_bank_low  <= wdat[5:0];
      if (ctrl_we)   ctrl_e800     <= wdat;
      if (prg_hi_we) prg_bank_high <= wdat[5:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= acc_mod ? ST_CALC : ST_DONE;
            step  <= '0;
          end
        end
        ST_CALC: begin
          step <= step + 1'b1;
          if (step == STEP_W'(cbm_pkg::DIV_CYCLES - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result and divide datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      res_rd   <= acc_rd;
      res_irq  <= pending_next;
      res_tgt  <= acc_tgt;
      res_page <= acc_page;
      div_num  <= acc_num;
      div_den  <= acc_den;
      div_rem  <= '0;
    end else if (state == ST_CALC) begin
      div_num <= num_w;
      div_rem <= rem_w;
      if (step == STEP_W'(cbm_pkg::DIV_CYCLES - 1)) begin
        // remainder never exceeds the 8-bit dividend
        res_page <= rem_w[7:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_rd   <= res_rd;
      out_irq  <= res_irq;
      out_tgt  <= res_tgt;
      out_page <= res_page;
    end
  end

  assign m_tdata = {7'd0, out_page, out_irq, out_rd};
  assign m_tuser = out_tgt;

endmodule

// ----- rtl/cbm_checker.sv -----
// ----------------------------------------------------------------------------
// cbm_checker: port-level checks for the cartridge bank mapper
// Watches the request and result channels only; bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // no target means no page
  a_none_no_page: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cbm_pkg::TGT_NONE |-> m_tdata[16:9] == 8'd0)
    else $error("page given without a target");

  // counter bytes only come back on unmapped reads
  a_rd_unmapped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tuser == cbm_pkg::TGT_NONE)
    else $error("read data on a mapped result");

  // padding stays zero, pattern RAM pages stay in range
  a_pad_and_ram: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:17] == 7'd0 &&
      (m_tuser != cbm_pkg::TGT_CHR_RAM ||
       m_tdata[16:9] < 8'(cbm_pkg::RAM_PAGES)))
    else $error("result padding or pattern RAM page out of range");

endmodule

bind cartridge_bank_mapper_with_irq cbm_checker u_cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- test/cartridge_bank_mapper_with_irq_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_test: self-checking bench for the bank mapper
// Drives CPU writes and reads, PPU lookups and ticks over the request stream.
// A shadow of the mapper state predicts each result, and every returned result
// is checked in order. The run covers several page-count settings, random
// gaps and stalls on both sides, one long output stall and full drains between phases.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_test;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES  = 300;   // long output stall
  localparam int SETTLE       = 10;    // longest request latency plus margin
  localparam int PHASE_ITEMS  = 203;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [2:0] map_target;
    logic [7:0] map_page;
  } map_result_t;

  // Shadow of the mapper: register file, IRQ counter and the results that
  // the accepted requests still owe.
  class bank_map_tracker;
    logic [6:0]  prg_count;
    logic [8:0]  chr_count;
    logic [14:0] irq_count;
    logic        irq_enable;
    logic        irq_pending;
    logic [1:0]  tick_phase;
    logic [7:0]  pattern_bank [cbm_pkg::PATTERN_SLOTS];
    logic [7:0]  nt_sel [cbm_pkg::NT_SLOTS];
    logic [5:0]  prg_low;
    logic [5:0]  prg_high;
    logic [7:0]  ctrl_e800;
    map_result_t expected_maps [$];
    int          errors;

    function new();
      prg_count   = cbm_pkg::PRG_COUNT_RESET;
      chr_count   = cbm_pkg::CHR_COUNT_RESET;
      irq_count   = '0;
      irq_enable  = 1'b0;
      irq_pending = 1'b0;
      tick_phase  = '0;
      foreach (pattern_bank[i]) pattern_bank[i] = '0;
      foreach (nt_sel[i]) nt_sel[i] = '0;
      prg_low     = '0;
      prg_high    = '0;
      ctrl_e800   = '0;
      errors      = 0;
    endfunction

    function void set_count(logic idx, logic [8:0] value);
      if (idx == cbm_pkg::CFG_PRG_COUNT) prg_count = value[6:0];
      else chr_count = value;
    endfunction

    // a zero page count behaves as a single page
    function logic [7:0] wrap(int unsigned page, int unsigned count);
      if (count == 0) return 8'd0;
      return 8'(page % count);
    endfunction

    function void cpu_write(logic [15:0] addr, logic [7:0] value);
      logic [15:0] sel;
      sel = addr & 16'hF800;
      if (!((addr >= 16'h4800 && addr < 16'h6000) || addr >= 16'h8000)) return;
      if (sel == 16'h5000) begin
        irq_count[7:0] = value;
        irq_pending = 1'b0;
      end else if (sel == 16'h5800) begin
        irq_count[14:8] = value[6:0];
        irq_enable = value[7];
        irq_pending = 1'b0;
      end else if (sel >= 16'h8000 && sel <= 16'hB800) begin
        pattern_bank[3'((sel - 16'h8000) >> 11)] = value;
      end else if (sel >= 16'hC000 && sel <= 16'hD800) begin
        nt_sel[2'((sel - 16'hC000) >> 11)] = value;
      end else if (sel == 16'hE000) begin
        prg_low = value[5:0];
      end else if (sel == 16'hE800) begin
        ctrl_e800 = value;
      end else if (sel == 16'hF000) begin
        prg_high = value[5:0];
      end
      // 0x4800 and 0xF800 are sound ports: nothing to track
    endfunction

    function void note_request(logic [1:0] cmd, logic [15:0] addr, logic [7:0] value);
      map_result_t r;
      logic [15:0] sel;
      logic [2:0]  slot;
      logic [7:0]  bank;
      logic        rom_only;
      int unsigned prg_bank;
      r = '0;
      sel = addr & 16'hF800;
      case (cmd)
        cbm_pkg::CMD_WRITE: cpu_write(addr, value);
        cbm_pkg::CMD_READ: begin
          if (addr >= 16'h4800 && addr < 16'h6000) begin
            if (sel == 16'h5000) begin
              r.read_data = irq_count[7:0];
              irq_pending = 1'b0;
            end else if (sel == 16'h5800) begin
              r.read_data = {1'b0, irq_count[14:8]};
              irq_pending = 1'b0;
            end
          end else if (addr >= 16'h8000) begin
            case (addr[14:13])
              2'd0: prg_bank = prg_low;
              2'd1: prg_bank = ctrl_e800[5:0];
              2'd2: prg_bank = prg_high;
              default: prg_bank = (prg_count == 0) ? 0 : prg_count - 1;
            endcase
            r.map_target = cbm_pkg::TGT_PRG_ROM;
            r.map_page   = wrap(prg_bank, prg_count);
          end
        end
        cbm_pkg::CMD_LOOKUP: begin
          if (addr < 16'h2000) begin
            slot = addr[12:10];
            bank = pattern_bank[slot];
            rom_only = (slot < 4) ? ctrl_e800[6] : ctrl_e800[7];
            if (bank < cbm_pkg::RAM_BASE || rom_only) begin
              r.map_target = cbm_pkg::TGT_CHR_ROM;
              r.map_page   = wrap(bank, chr_count);
            end else begin
              r.map_target = cbm_pkg::TGT_CHR_RAM;
              r.map_page   = (bank - cbm_pkg::RAM_BASE) & 8'(cbm_pkg::RAM_PAGES - 1);
            end
          end else if (addr < 16'h3000) begin
            bank = nt_sel[addr[11:10]];
            if (bank >= cbm_pkg::RAM_BASE) begin
              r.map_target = cbm_pkg::TGT_NT_RAM;
              r.map_page   = {7'd0, bank[0]};
            end else begin
              r.map_target = cbm_pkg::TGT_CHR_ROM;
              r.map_page   = wrap(bank, chr_count);
            end
          end
        end
        default: begin
          // prescaler: the counter moves on every third tick
          tick_phase = tick_phase + 2'd1;
          if (tick_phase == 2'd3) begin
            tick_phase = '0;
            if (irq_enable) begin
              if (irq_count == cbm_pkg::CNT_MAX) irq_pending = 1'b1;
              else irq_count = irq_count + 15'd1;
            end
          end
        end
      endcase
      r.irq_line = irq_pending;
      expected_maps.push_back(r);
    endfunction

    function void check_result(logic [7:0] rd, logic irq, logic [2:0] tgt, logic [7:0] page);
      map_result_t e;
      if (expected_maps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = expected_maps.pop_front();
      if (rd !== e.read_data) begin
        $error("read_data: expected %0h, got %0h", e.read_data, rd);
        errors++;
      end
      if (irq !== e.irq_line) begin
        $error("irq_line: expected %0b, got %0b", e.irq_line, irq);
        errors++;
      end
      if (tgt !== e.map_target) begin
        $error("map_target: expected %0d, got %0d", e.map_target, tgt);
        errors++;
      end
      if (page !== e.map_page) begin
        $error("map_page: expected %0h, got %0h", e.map_page, page);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [15:0] address, [23:16] data
  logic [1:0]  s_tuser;   // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] read_data, [8] irq_line, [16:9] map_page
  logic [2:0]  m_tuser;   // [2:0] map_target
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  bank_map_tracker shadow = new();

  int requests_sent;
  int idle_cycles;
  bit quiet_phase;     // no gaps on either side
  bit hold_off_req;    // ask the receiver for one long stall

  cartridge_bank_mapper_with_irq dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 8'($urandom_range(8'hE0, 8'hFF));   // RAM range of banks
    if (r == 1) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one request and hold it until the mapper takes it
  task automatic send_request(logic [1:0] cmd, logic [15:0] addr, logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {value, addr};
    do @(posedge clk); while (!s_tready);
    shadow.note_request(cmd, addr, value);
    requests_sent++;
  endtask

  // stop offering, wait for every owed result, then let the pipe go quiet
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (shadow.expected_maps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_page_counts(logic [8:0] prg, logic [8:0] chr);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= cbm_pkg::CFG_PRG_COUNT;
    cfg_data  <= prg;
    @(posedge clk);
    shadow.set_count(cbm_pkg::CFG_PRG_COUNT, prg);
    cfg_index <= cbm_pkg::CFG_CHR_COUNT;
    cfg_data  <= chr;
    @(posedge clk);
    shadow.set_count(cbm_pkg::CFG_CHR_COUNT, chr);
    cfg_we    <= 1'b0;
  endtask

  // counter programmed near its top, then a run of ticks with stray reads
  task automatic counter_run();
    int n;
    logic [15:0] a;
    send_request(cbm_pkg::CMD_WRITE, 16'h5000 | 16'($urandom_range(0, 16'h7FF)),
                 8'($urandom_range(8'hF0, 8'hFF)));
    send_request(cbm_pkg::CMD_WRITE, 16'h5800 | 16'($urandom_range(0, 16'h7FF)),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'h80 | 8'($urandom_range(8'h7C, 8'h7F)));
    n = $urandom_range(10, 70);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        a = ($urandom_range(0, 1) ? 16'h5000 : 16'h5800) | 16'($urandom_range(0, 16'h7FF));
        send_request(cbm_pkg::CMD_READ, a, 8'($urandom_range(0, 255)));
      end else begin
        send_request(cbm_pkg::CMD_TICK, 16'($urandom_range(0, 16'hFFFF)),
                     8'($urandom_range(0, 255)));
      end
    end
  endtask

  // bank registers rewritten, then read back through lookups and program reads
  task automatic bank_run();
    int k;
    int m;
    logic [15:0] a;
    k = $urandom_range(1, 4);
    repeat (k)
      send_request(cbm_pkg::CMD_WRITE,
                   {5'($urandom_range(16, 30)), 11'($urandom_range(0, 16'h7FF))},
                   pick_byte());
    m = $urandom_range(2, 8);
    repeat (m) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(cbm_pkg::CMD_READ, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                     8'($urandom_range(0, 255)));
      end else begin
        a = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                        : 16'($urandom_range(0, 16'h2FFF));
        send_request(cbm_pkg::CMD_LOOKUP, a, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic stray_request();
    logic [1:0] cmd;
    logic [15:0] a;
    cmd = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1))
      a = 16'($urandom_range(0, 16'hFFFF));
    else
      a = {5'($urandom_range(9, 31)), 11'($urandom_range(0, 16'h7FF))};
    send_request(cmd, a, pick_byte());
  endtask

  task automatic random_phase(int count);
    int stop_at;
    int r;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 25) counter_run();
      else if (r < 65) bank_run();
      else stray_request();
    end
  endtask

  // receiver: random ready gaps, plus one long hold-off on request
  initial begin
    int gap;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_result(m_tdata[7:0], m_tdata[8], m_tuser, m_tdata[16:9]);
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("cartridge_bank_mapper_with_irq verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0] prg_set [8];
    logic [8:0] chr_set [8];
    requests_sent = 0;
    quiet_phase   = 1'b0;
    hold_off_req  = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = cbm_pkg::CMD_WRITE;
    cfg_we    = 1'b0;
    cfg_index = cbm_pkg::CFG_PRG_COUNT;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part, reset page counts ---
    // counter parked at its top with enable, IRQ raised by the third tick
    send_request(cbm_pkg::CMD_WRITE, 16'h5000, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'h5800, 8'hFF);
    repeat (4) send_request(cbm_pkg::CMD_TICK, 16'hFFFF, 8'hFF);
    // counter reads return both halves and clear the IRQ
    send_request(cbm_pkg::CMD_READ, 16'h5000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'h5FFF, 8'h00);
    // bank registers at their extremes
    send_request(cbm_pkg::CMD_WRITE, 16'h8000, 8'hE0);
    send_request(cbm_pkg::CMD_WRITE, 16'hBFFF, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'hC000, 8'hE1);
    send_request(cbm_pkg::CMD_WRITE, 16'hDC00, 8'h7F);
    send_request(cbm_pkg::CMD_WRITE, 16'hE000, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'hE800, 8'hC5);   // ROM-only for both halves, bank 5
    send_request(cbm_pkg::CMD_WRITE, 16'hF000, 8'h21);
    // sound ports and unmapped ranges leave everything alone
    send_request(cbm_pkg::CMD_WRITE, 16'h4800, 8'h55);
    send_request(cbm_pkg::CMD_WRITE, 16'hF800, 8'hAA);
    send_request(cbm_pkg::CMD_WRITE, 16'h6000, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'h0000, 8'hFF);
    // RAM banks forced to ROM, nametable RAM and ROM, out of range lookup
    send_request(cbm_pkg::CMD_LOOKUP, 16'h0000, 8'h00);
    send_request(cbm_pkg::CMD_LOOKUP, 16'h1FFF, 8'h00);
    send_request(cbm_pkg::CMD_LOOKUP, 16'h2000, 8'h00);
    send_request(cbm_pkg::CMD_LOOKUP, 16'h2FFF, 8'h00);
    send_request(cbm_pkg::CMD_LOOKUP, 16'h3000, 8'h00);
    // all four program windows, fixed last page included
    send_request(cbm_pkg::CMD_READ, 16'h8000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'hA000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'hC000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'hFFFF, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'h7FFF, 8'h00);
    // clear ROM-only: pattern RAM pages become visible
    send_request(cbm_pkg::CMD_WRITE, 16'hE800, 8'h00);
    send_request(cbm_pkg::CMD_LOOKUP, 16'h0000, 8'h00);
    send_request(cbm_pkg::CMD_LOOKUP, 16'h1C00, 8'h00);

    // --- random part over several page-count settings ---
    prg_set = '{9'd64, 9'd1, 9'd0, 9'd127, 9'h1C1, 9'd63, 9'd0, 9'd0};
    chr_set = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd13, 9'd255, 9'd0, 9'd0};
    prg_set[6] = 9'($urandom_range(1, 64));
    chr_set[6] = 9'($urandom_range(1, 256));
    prg_set[7] = 9'($urandom_range(0, 127));
    chr_set[7] = 9'($urandom_range(0, 511));
    for (int p = 0; p < 8; p++) begin
      load_page_counts(prg_set[p], chr_set[p]);
      quiet_phase = (p == 2);
      if (p == 1) hold_off_req = 1'b1;   // output backs up while requests keep coming
      if (p == 4) begin
        random_phase(PHASE_ITEMS / 2);
        drain_results();
        random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        random_phase(PHASE_ITEMS);
      end
    end
    quiet_phase = 1'b0;

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (shadow.errors == 0 && shadow.expected_maps.size() == 0)
      $display("cartridge_bank_mapper_with_irq verification clean");
    else
      $display("cartridge_bank_mapper_with_irq verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cbm_pkg.sv
rtl/cartridge_bank_mapper_with_irq.sv
rtl/cbm_checker.sv
test/cartridge_bank_mapper_with_irq_test.sv
